// File: hw/rtl/ksd_pkg.sv
`default_nettype none

package ksd_pkg;

    localparam int STEP_W     = 32;
    localparam int POS_W      = 4;
    localparam int CODE_W     = 10;
    localparam int VALUE_W    = 2;
    localparam int TIME_W     = 32;
    localparam int TIMEOUT_W  = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 4;

    // Configuration register map
    localparam logic [CFG_IDX_W-1:0] REG_SEQ_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_PAIR_0 = 3'd1;

    // Key event values
    localparam logic [VALUE_W-1:0] KEY_RELEASE = 2'd0;
    localparam logic [VALUE_W-1:0] KEY_PRESS   = 2'd1;
    localparam logic [VALUE_W-1:0] KEY_REPEAT  = 2'd2;

    typedef struct packed {
        logic [CODE_W-1:0]  key_code;
        logic [VALUE_W-1:0] key_value;
        logic [TIME_W-1:0]  time_ms;
    } key_event_t;

    typedef struct packed {
        logic             matched;
        logic [POS_W-1:0] position;
    } key_result_t;

    // One step word, bit 31 down to bit 0
    typedef struct packed {
        logic                 untimed;
        logic [TIMEOUT_W-1:0] timeout;
        logic [VALUE_W-1:0]   value;
        logic                 any_key;
        logic [CODE_W-1:0]    code;
    } step_t;

    // Next state and result produced for one event
    typedef struct packed {
        logic              matched;
        logic [POS_W-1:0]  step_index;
        logic [TIME_W-1:0] last_check_ms;
    } ksd_update_t;

endpackage

`default_nettype wire

// File: hw/rtl/key_sequence_detector.sv
`default_nettype none

// Channel   Dir  Handshake          Payload
// evt       in   evt_valid/stall    ksd_pkg::key_event_t  (code, value, time)
// res       out  res_valid/stall    ksd_pkg::key_result_t (matched, position)
// cfg       in   cfg_valid/ready    cfg_index (3b), cfg_data (64b)
//
// One event per cycle sustained while res is not stalled. A transfer on evt loads
// the input register; the whole step check (timeout subtract/compare, code compare,
// advance) sits between it and the result register, which drives res. Reset clears
// the position, the timestamp, the length (to 1) and all steps. A stall on res holds
// the result register, then the input register behind it. cfg_ready is always high;
// user writes must wait until no event is in flight; the block does not enforce it.

module key_sequence_detector #(
    parameter int MAX_STEPS = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            evt_valid,
    output logic                                 evt_stall,
    input  wire ksd_pkg::key_event_t             evt_data,

    output logic                                 res_valid,
    input  wire logic                            res_stall,
    output ksd_pkg::key_result_t                 res_data,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ksd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ksd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Configuration storage
    ksd_pkg::step_t            steps [MAX_STEPS];
    logic [ksd_pkg::LEN_W-1:0] eff_length;

    assign cfg_ready = 1'b1;

    ksd_step_regs #(
        .MAX_STEPS (MAX_STEPS)
    ) u_step_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .steps      (steps),
        .eff_length (eff_length)
    );

    // Input register
    logic                 in_valid_reg;
    ksd_pkg::key_event_t  in_data_reg;
    logic                 advance;
    logic                 evt_take;

    // Advance the input item when the result register is free or draining
    assign advance   = in_valid_reg && (!res_valid || !res_stall);
    assign evt_stall = in_valid_reg && !advance;
    assign evt_take  = evt_valid && !evt_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (evt_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            in_data_reg <= evt_data;
        end
    end

    // Sequence state, updated as each event moves into the result register
    logic [ksd_pkg::POS_W-1:0]  step_index_reg;
    logic [ksd_pkg::TIME_W-1:0] last_check_ms_reg;
    ksd_pkg::ksd_update_t       upd;

    ksd_seq_step #(
        .MAX_STEPS (MAX_STEPS)
    ) u_seq_step (
        .evt           (in_data_reg),
        .step_index    (step_index_reg),
        .last_check_ms (last_check_ms_reg),
        .steps         (steps),
        .eff_length    (eff_length),
        .upd           (upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_index_reg    <= '0;
            last_check_ms_reg <= '0;
        end
        else if (advance)
        begin
            step_index_reg    <= upd.step_index;
            last_check_ms_reg <= upd.last_check_ms;
        end
    end

    // Result register
    logic                  res_valid_reg;
    ksd_pkg::key_result_t  res_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_data_reg.matched  <= upd.matched;
            res_data_reg.position <= upd.step_index;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // The position never runs past the longest combination
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_index_reg <= ksd_pkg::POS_W'(MAX_STEPS))
        else $error("step index beyond MAX_STEPS");

    // A match always reports a nonzero position
    a_match_pos: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.matched |-> res_data.position != '0)
        else $error("match with position zero");

    // A transfer on evt always lands in the input register
    a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_stall |=> in_valid_reg)
        else $error("accepted event lost");

    // Results appear only after an event advanced out of the input register
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(in_valid_reg))
        else $error("result without event");

endmodule

`default_nettype wire

// File: hw/rtl/ksd_step_regs.sv
`default_nettype none

module ksd_step_regs #(
    parameter int MAX_STEPS = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [ksd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [ksd_pkg::CFG_DATA_W-1:0]      cfg_data,
    output ksd_pkg::step_t                           steps [MAX_STEPS],
    output logic [ksd_pkg::LEN_W-1:0]                eff_length
);

    localparam logic [ksd_pkg::LEN_W-1:0] MAX_LEN = ksd_pkg::LEN_W'(MAX_STEPS);

    logic [ksd_pkg::LEN_W-1:0] seq_length_reg;
    ksd_pkg::step_t            step_reg [MAX_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_length_reg <= ksd_pkg::LEN_W'(1);
        end
        else if (cfg_write && cfg_index == ksd_pkg::REG_SEQ_LENGTH)
        begin
            seq_length_reg <= cfg_data[ksd_pkg::LEN_W-1:0];
        end
    end

    // Each step lives in one half of its pair register
    for (genvar k = 0; k < MAX_STEPS; k++)
    begin : g_step
        localparam logic [ksd_pkg::CFG_IDX_W-1:0] PAIR_IDX =
            ksd_pkg::CFG_IDX_W'(ksd_pkg::REG_STEP_PAIR_0 + k / 2);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                step_reg[k] <= '0;
            end
            else if (cfg_write && cfg_index == PAIR_IDX)
            begin
                step_reg[k] <= cfg_data[(k % 2) * ksd_pkg::STEP_W +: ksd_pkg::STEP_W];
            end
        end

        assign steps[k] = step_reg[k];
    end

    // Clamp the length to 1..MAX_STEPS
    always_comb
    begin
        if (seq_length_reg == '0)
        begin
            eff_length = ksd_pkg::LEN_W'(1);
        end
        else if (seq_length_reg > MAX_LEN)
        begin
            eff_length = MAX_LEN;
        end
        else
        begin
            eff_length = seq_length_reg;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/ksd_seq_step.sv
`default_nettype none

module ksd_seq_step #(
    parameter int MAX_STEPS = 8
) (
    input  wire ksd_pkg::key_event_t         evt,
    input  wire logic [ksd_pkg::POS_W-1:0]   step_index,
    input  wire logic [ksd_pkg::TIME_W-1:0]  last_check_ms,
    input  wire ksd_pkg::step_t              steps [MAX_STEPS],
    input  wire logic [ksd_pkg::LEN_W-1:0]   eff_length,
    output ksd_pkg::ksd_update_t             upd
);

    localparam int IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    logic [ksd_pkg::POS_W-1:0]  cur_idx;
    logic [ksd_pkg::POS_W-1:0]  timed_idx;
    logic [ksd_pkg::POS_W-1:0]  next_idx;
    ksd_pkg::step_t             cur_step;
    ksd_pkg::step_t             chk_step;
    logic [ksd_pkg::TIME_W-1:0] elapsed;
    logic                       expired;
    logic                       hit;

    always_comb
    begin
        // Wrap back to the first step after a completed combination
        cur_idx  = (step_index >= eff_length) ? '0 : step_index;
        cur_step = steps[cur_idx[IDX_W-1:0]];

        elapsed = evt.time_ms - last_check_ms;
        expired = !cur_step.untimed &&
                  (elapsed > ksd_pkg::TIME_W'(cur_step.timeout));

        timed_idx = expired ? '0 : cur_idx;
        chk_step  = expired ? steps[0] : cur_step;

        hit = (evt.key_value == chk_step.value) &&
              (chk_step.any_key || evt.key_code == chk_step.code);

        if (evt.key_value == ksd_pkg::KEY_REPEAT)
        begin
            next_idx = timed_idx;
        end
        else if (hit)
        begin
            next_idx = timed_idx + ksd_pkg::POS_W'(1);
        end
        else
        begin
            next_idx = '0;
        end

        upd.step_index    = next_idx;
        upd.last_check_ms = cur_step.untimed ? last_check_ms : evt.time_ms;
        upd.matched       = (next_idx >= eff_length);
    end

endmodule

`default_nettype wire
